### rtl/utf8_to_utf32_stream_decoder_macros.svh
// Assertion helpers for the UTF-8 to UTF-32 decoder.
`ifndef UTF8_TO_UTF32_STREAM_DECODER_MACROS_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8D_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, disabled during reset.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

### rtl/u8dec_pkg.sv
`timescale 1ns / 1ps

package u8dec_pkg;

  // Result word kinds
  localparam logic [1:0] KindCode = 2'd0;
  localparam logic [1:0] KindBom  = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  // Configuration register indexes
  localparam logic RegBigEndian = 1'b0;
  localparam logic RegEmitBom   = 1'b1;

  // Byte order marks in each output byte order
  localparam logic [31:0] BomLittle = 32'h0000_FEFF;
  localparam logic [31:0] BomBig    = 32'hFFFE_0000;

  // Result queue: holds the worst-case burst of three items plus one in flight
  localparam int ResDepth = 4;
  localparam int MaxPush  = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;
  } src_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [1:0]  word_kind;
    logic        success;
    logic        last_of_run;
  } res_item_t;

endpackage

### rtl/utf8_to_utf32_stream_decoder.sv
// Channel  Direction  Handshake              Payload
// src      in         src_valid / src_stall  src_item  (one UTF-8 byte, end mark)
// res      out        res_valid / res_stall  res_item  (UTF-32 word, BOM or status)
// cfg      in         cfg_we                 cfg_index, cfg_data
//
// Each byte is decoded in the cycle it is transferred; its zero to three results
// go to a four-entry result queue and leave one per cycle while res_stall is low.
// Sustained rate is one byte per cycle while each byte yields at most one result
// and res_stall is low; a BOM or end status adds a result to the single port.
// src_stall rises when the queue has fewer than three free entries.
// rst is synchronous and clears the decoder state, registers and the queue.
`timescale 1ns / 1ps

`include "utf8_to_utf32_stream_decoder_macros.svh"

module utf8_to_utf32_stream_decoder
  import u8dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  src_item_t src_item,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_data
);

  localparam int PtrW = $clog2(ResDepth);
  localparam int CntW = $clog2(ResDepth + 1);

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Configuration registers
  logic big_endian_out;
  logic emit_bom;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian_out <= 1'b0;
      emit_bom       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBigEndian: big_endian_out <= cfg_data;
        RegEmitBom:   emit_bom       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] code_accum, code_accum_next;
  logic        bom_sent, bom_sent_next;
  logic        failed, failed_next;

  // Result queue
  res_item_t           qmem [ResDepth];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;
  logic                src_fire, res_fire;
  logic                active;
  logic                emit_b, emit_c, emit_e;
  logic [1:0]          push_n;
  res_item_t           bom_item, code_item, end_item;
  res_item_t           slot [MaxPush];
  logic [7:0]          b;

  assign src_stall = (count > CntW'(ResDepth - MaxPush));
  assign src_fire  = src_valid && !src_stall;
  assign res_valid = (count != '0);
  assign res_fire  = res_valid && !res_stall;
  assign res_item  = qmem[rd_ptr];
  assign b         = src_item.data_byte;
  assign active    = src_item.has_byte || src_item.end_of_string;

  // Byte decode and result assembly
  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    bom_sent_next      = bom_sent;
    failed_next        = failed;
    emit_c             = 1'b0;

    emit_b = active && !bom_sent && emit_bom;
    if (active) begin
      bom_sent_next = 1'b1;
    end

    code_item.out_word = '0;
    if (src_item.has_byte && !failed) begin
      if (bytes_pending != 2'd0) begin
        code_accum_next    = {code_accum[14:0], b[5:0]};
        bytes_pending_next = bytes_pending - 2'd1;
        emit_c             = (bytes_pending == 2'd1);
      end else if (b[7:4] == 4'hF) begin
        code_accum_next    = {18'd0, b[2:0]};
        bytes_pending_next = 2'd3;
      end else if (b[7:5] == 3'h7) begin
        code_accum_next    = {17'd0, b[3:0]};
        bytes_pending_next = 2'd2;
      end else if (b[7:6] == 2'h3) begin
        code_accum_next    = {16'd0, b[4:0]};
        bytes_pending_next = 2'd1;
      end else if (!b[7]) begin
        code_accum_next = {13'd0, b};
        emit_c          = 1'b1;
      end else begin
        failed_next     = 1'b1;
        code_accum_next = '0;
      end
      if (emit_c) begin
        code_item.out_word = big_endian_out ? swap32({11'd0, code_accum_next})
                                            : {11'd0, code_accum_next};
        code_accum_next    = '0;
      end
    end

    emit_e = src_item.end_of_string;

    // End status: check uses state after this byte, then clears the string
    end_item.out_word    = '0;
    end_item.word_kind   = KindEnd;
    end_item.success     = !failed_next && (bytes_pending_next == 2'd0);
    end_item.last_of_run = 1'b1;
    if (emit_e) begin
      bytes_pending_next = 2'd0;
      code_accum_next    = '0;
      bom_sent_next      = 1'b0;
      failed_next        = 1'b0;
    end

    bom_item.out_word    = big_endian_out ? BomBig : BomLittle;
    bom_item.word_kind   = KindBom;
    bom_item.success     = 1'b0;
    bom_item.last_of_run = !emit_c && !emit_e;

    code_item.word_kind   = KindCode;
    code_item.success     = 1'b0;
    code_item.last_of_run = !emit_e;

    // Pack results in order BOM, code point, status
    slot[0] = emit_b ? bom_item : (emit_c ? code_item : end_item);
    slot[1] = (emit_b && emit_c) ? code_item : end_item;
    slot[2] = end_item;
    push_n  = 2'({1'b0, emit_b} + {1'b0, emit_c} + {1'b0, emit_e});
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      code_accum    <= '0;
      bom_sent      <= 1'b0;
      failed        <= 1'b0;
    end else if (src_fire) begin
      bytes_pending <= bytes_pending_next;
      code_accum    <= code_accum_next;
      bom_sent      <= bom_sent_next;
      failed        <= failed_next;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxPush; k++) begin
      if (src_fire && (k < int'(push_n))) begin
        qmem[wr_ptr + PtrW'(k)] <= slot[k];
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (src_fire) begin
        wr_ptr <= wr_ptr + PtrW'(push_n);
      end
      if (res_fire) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (src_fire ? CntW'(push_n) : CntW'(0)) - CntW'(res_fire);
    end
  end

  // Checks
  `U8D_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CntW'(ResDepth))
  `U8D_ASSERT_NOW(a_failed_clean, clk, rst, failed,
                  (bytes_pending == 2'd0) && (code_accum == '0))
  `U8D_ASSERT_NEXT(a_end_clears, clk, rst, src_fire && src_item.end_of_string,
                   (bytes_pending == 2'd0) && !failed && !bom_sent)
  `U8D_ASSERT_NOW(a_success_kind, clk, rst, res_valid && res_item.success,
                  (res_item.word_kind == KindEnd) && res_item.last_of_run)

endmodule
